FILE: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the sha-256 stream hasher
// round constants, initial hash value and queue entry types
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // one queued block: 16 big-endian words, plus a flag for the final block
  typedef struct packed {
    logic [511:0] blk;
    logic         fin;
  } blk_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_BYTES,
    FR_PAD2
  } fr_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

endpackage
`default_nettype wire

FILE: sv/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front: byte packer and padder
// packs message bytes into 512-bit blocks, pads on finish, pushes blocks
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              op,
  input  wire logic [7:0]        data_byte,
  output logic                   push,
  output sha_pkg::blk_entry_t    push_entry,
  input  wire logic              q_full
);

  sha_pkg::fr_state_t state, state_next;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [511:0] pad_blk;
  logic [63:0]  bits;
  logic         acc;

  assign bits = {total[60:0], 3'b000};

  // block with 0x80 at fill position and zeros after it
  always_comb begin
    pad_blk = blk;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == fill) pad_blk[511-8*i -: 8] = sha_pkg::PadMark;
      else if (6'(i) > fill) pad_blk[511-8*i -: 8] = 8'h00;
    end
  end

  assign in_ready = (state == sha_pkg::FR_BYTES) && !q_full;
  assign acc = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::FR_BYTES: if (acc && op && fill >= sha_pkg::LenPos) state_next = sha_pkg::FR_PAD2;
      sha_pkg::FR_PAD2:  if (!q_full) state_next = sha_pkg::FR_BYTES;
      default:           state_next = sha_pkg::FR_BYTES;
    endcase
  end

  // push outputs
  always_comb begin
    push = 1'b0;
    push_entry.blk = pad_blk;
    push_entry.fin = 1'b0;
    case (state)
      sha_pkg::FR_BYTES: begin
        if (acc && !op && fill == 6'd63) begin
          push = 1'b1;
          push_entry.blk = {blk[511:8], data_byte};
        end else if (acc && op) begin
          push = 1'b1;
          if (fill < sha_pkg::LenPos) begin
            push_entry.blk = {pad_blk[511:64], bits};
            push_entry.fin = 1'b1;
          end
        end
      end
      sha_pkg::FR_PAD2: begin
        push = !q_full;
        push_entry.blk = {448'd0, bits};
        push_entry.fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::FR_BYTES;
      fill  <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      if (acc && !op) begin
        fill  <= fill + 6'd1;
        total <= total + 64'd1;
      end
      if (state == sha_pkg::FR_BYTES && acc && op && fill < sha_pkg::LenPos) begin
        fill  <= '0;
        total <= '0;
      end
      if (state == sha_pkg::FR_PAD2 && !q_full) begin
        fill  <= '0;
        total <= '0;
      end
    end
  end

  // byte store, big-endian
  always_ff @(posedge clk) begin
    if (acc && !op) blk[511-8*fill -: 8] <= data_byte;
  end

endmodule
`default_nettype wire

FILE: sv/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue: block queue
// short fifo of message and padded blocks between packer and compressor
// ----------------------------------------------------------------------------
`default_nettype none
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  sha_pkg::blk_entry_t  push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output sha_pkg::blk_entry_t  head
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::blk_entry_t mem [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0]   cnt;

  assign full  = cnt == (Aw+1)'(Depth);
  assign empty = cnt == '0;
  assign head  = mem[rp];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push && !full) wp <= (wp == Aw'(Depth-1)) ? '0 : wp + Aw'(1);
      if (pop && !empty) rp <= (rp == Aw'(Depth-1)) ? '0 : rp + Aw'(1);
      cnt <= cnt + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= push_entry;
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |=> !(cnt > (Aw+1)'(Depth))) else $error("queue overflow");
  ap_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> cnt == $past(cnt) + (Aw+1)'(1))
    else $error("queue count step");
  ap_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty) else $error("queue empty drift");

endmodule
`default_nettype wire

FILE: sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: compression engine
// one round a cycle over a block from the queue; after the final block it emits the digest
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  sha_pkg::blk_entry_t  q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_index,
  output logic                 last
);

  sha_pkg::bk_state_t state, state_next;
  logic [31:0] h [8];
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [5:0]  t;
  logic        fin;
  logic [2:0]  idx;
  logic [31:0] s0, s1, ch, mj, b0, b1, t1, t2, wn;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // round datapath and message schedule
  always_comb begin
    b1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
    ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
    t1 = r[7] + b1 + ch + sha_pkg::round_k(t) + w[0];
    b0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
    mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
    t2 = b0 + mj;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::BK_IDLE:  if (!q_empty) state_next = sha_pkg::BK_ROUND;
      sha_pkg::BK_ROUND: if (t == 6'd63) state_next = sha_pkg::BK_ADD;
      sha_pkg::BK_ADD:   state_next = fin ? sha_pkg::BK_EMIT : sha_pkg::BK_IDLE;
      sha_pkg::BK_EMIT:  if (out_ready && idx == 3'd7) state_next = sha_pkg::BK_IDLE;
      default:           state_next = sha_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop         = (state == sha_pkg::BK_IDLE) && !q_empty;
    out_valid   = state == sha_pkg::BK_EMIT;
    digest_word = h[idx];
    word_index  = idx;
    last        = idx == 3'd7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::BK_IDLE;
      idx   <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::InitHash[255-32*i -: 32];
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::BK_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + r[i];
          idx <= '0;
        end
        sha_pkg::BK_EMIT: if (out_ready) begin
          idx <= idx + 3'd1;
          if (idx == 3'd7)
            for (int i = 0; i < 8; i++) h[i] <= sha_pkg::InitHash[255-32*i -: 32];
        end
        default: ;
      endcase
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (state == sha_pkg::BK_IDLE && !q_empty) begin
      for (int i = 0; i < 8; i++) r[i] <= h[i];
      for (int i = 0; i < 16; i++) w[i] <= q_head.blk[511-32*i -: 32];
      fin <= q_head.fin;
      t   <= '0;
    end else if (state == sha_pkg::BK_ROUND) begin
      r[0] <= t1 + t2; r[1] <= r[0]; r[2] <= r[1]; r[3] <= r[2];
      r[4] <= r[3] + t1; r[5] <= r[4]; r[6] <= r[5]; r[7] <= r[6];
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      t <= t + 6'd1;
    end
  end

  ap_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == sha_pkg::BK_ROUND) else $error("pop without start");
  ap_emit_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> state == sha_pkg::BK_IDLE) else $error("emit end");
  ap_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::BK_ADD) |=> idx == 3'd0) else $error("index start");

endmodule
`default_nettype wire

FILE: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: sha-256 of a byte stream
// packer/padder front, block queue, round-per-cycle compressor back
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)          | tuser
// s_axis  | in  | data_byte[7:0]                     | op
// m_axis  | out | digest_word[31:0], word_index[34:32] | -, tlast = last
//
// a byte word is taken in one cycle while the block queue has room
// each block in the compressor is loaded, run through 64 rounds, then added into the hash state
// a finish word pushes one or two padded blocks, then eight digest words
// rst is synchronous; hash state returns to the initial value after each digest
// a stall on m_axis holds the compressor; the front stalls while the queue is full
// and after a finish word that needs a second padded block, until it pushes that block
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word, word_index, zero fill
  output logic             m_axis_tlast    // last
);

  logic                q_push, q_full, q_pop, q_empty;
  sha_pkg::blk_entry_t q_in, q_head;
  logic [31:0]         dw;
  logic [2:0]          wi;

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tuser), .data_byte(s_axis_tdata),
    .push(q_push), .push_entry(q_in), .q_full(q_full)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .push(q_push), .push_entry(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  sha_core u_core (
    .clk, .rst,
    .q_empty(q_empty), .q_head(q_head), .pop(q_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(dw), .word_index(wi), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, wi, dw};

endmodule
`default_nettype wire

FILE: sim/sha256_hasher_checker.sv
// ----------------------------------------------------------------------------
// sha256_hasher_checker: digest predictor and scoreboard
// watches both channels, hashes accepted bytes, compares digest words
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256_hasher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending,
  output logic        any_accept
);

  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        lst;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0]  hstate [8];
  logic [7:0]   blk_buf [64];
  int unsigned  fill;
  logic [63:0]  nbytes;

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // one compression of blk_buf into hstate
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, lo, hi;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      lo = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      hi = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + lo + w[t-7] + hi;
    end
    for (int i = 0; i < 8; i++) r[i] = hstate[i];
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::round_k(t[5:0]) + w[t];
      t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hstate[i] += r[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hstate[i] = sha_pkg::InitHash[255-32*i -: 32];
    fill = 0;
    nbytes = '0;
  endtask

  task automatic absorb(input logic [7:0] b);
    nbytes++;
    blk_buf[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  // padding, length, final compression and digest words
  task automatic finish_msg();
    logic [63:0] bits;
    digest_word_t d;
    bits = nbytes << 3;
    blk_buf[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin blk_buf[fill] = 8'h00; fill++; end
      compress();
      fill = 0;
    end
    while (fill < 56) begin blk_buf[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.dword = hstate[i];
      d.idx = i[2:0];
      d.lst = (i == 7);
      digest_q.push_back(d);
    end
    restart();
  endtask

  initial begin
    fail_count = 0;
    restart();
  end

  always @(posedge clk) begin
    digest_word_t e;
    logic seen;
    seen = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen = 1'b1;
        if (s_axis_tuser == OpFinish) finish_msg();
        else absorb(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = 1'b1;
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          e = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== e.dword || m_axis_tdata[34:32] !== e.idx ||
              m_axis_tdata[39:35] !== 5'b0 || m_axis_tlast !== e.lst) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: expected %h idx %0d last %b, got %h last %b",
                       e.dword, e.idx, e.lst, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
    any_accept <= seen;
    pending <= digest_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the sha-256 stream hasher
// drives directed and random messages through several idling phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;
  localparam int   IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  logic        any_accept;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  int          idle_cycles = 0;
  int          total_words = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sha256_stream_hasher uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  sha256_hasher_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count), .pending(pending), .any_accept(any_accept)
  );

  // receiver: random stalls, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || any_accept) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  // offer one word and hold it until taken
  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(255));
      s_axis_tuser  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    total_words++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop the offer once a stretch of sending is over
  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'($urandom_range(255));
    s_axis_tuser  <= 1'($urandom_range(1));
    @(negedge clk);
  endtask

  task automatic send_msg(input int len, input int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0:       b = 8'($urandom_range(255));
        1:       b = 8'hff;
        2:       b = 8'h00;
        default: b = i[7:0];
      endcase
      send_word(OpAbsorb, b);
    end
    send_word(OpFinish, 8'($urandom_range(255)));
  endtask

  task automatic random_phase(input int sidle, input int rstall, input int nwords);
    int target;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    target = total_words + nwords;
    while (total_words < target) begin
      // mostly short messages, now and then a multi-block one
      if ($urandom_range(9) == 0) send_msg($urandom_range(100, 64), 0);
      else send_msg($urandom_range(40), $urandom_range(3));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: empty message, pad boundaries, extreme byte values
    send_msg(0, 0);
    send_msg(1, 1);
    send_msg(1, 2);
    send_msg(3, 3);
    send_msg(55, 0);
    send_msg(56, 0);
    send_msg(63, 1);
    send_msg(64, 2);
    stop_sending();
    // sender pauses until every digest word has come
    while (pending != 0) @(negedge clk);
    random_phase(0, 0, 20);
    // receiver holds off while the sender keeps offering
    hold_off = 2000;
    for (int m = 0; m < 6; m++) send_msg($urandom_range(20), 0);
    random_phase(61, 0, 20);
    random_phase(0, 61, 20);
    random_phase(18, 18, 20);
    stop_sending();
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_stream_hasher.sv
sim/sha256_hasher_checker.sv
sim/tb_top.sv
